// ===== rtl/gtcl_pkg.sv =====
// Shared constants and types for the Gregorian to Chinese lunar date converter.
package gtcl_pkg;

	localparam int TABLE_YEARS = 152;
	localparam int IDX_W = $clog2(TABLE_YEARS);
	localparam int D_W = 17;
	localparam int WORD_W = 17;

	localparam logic [11:0] BASE_YEAR = 12'd1900;
	localparam logic [11:0] TOP_YEAR = 12'(TABLE_YEARS - 1) + BASE_YEAR;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_YEARS - 1);

	typedef logic alu_op_t;
	localparam alu_op_t ALU_ADD = 1'b0;
	localparam alu_op_t ALU_SUB = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [3:0] leap_mon;
		logic [8:0] year_len;
	} rom_info_t;

endpackage

// ===== rtl/gtcl_alu.sv =====
// Shared add/subtract and compare unit for the day counter.
module gtcl_alu
	import gtcl_pkg::*;
(
	input alu_op_t op,
	input logic [D_W-1:0] a,
	input logic [D_W-1:0] b,
	output logic [D_W-1:0] res,
	output logic le
);

	always_comb begin
		unique case (op)
			ALU_ADD: res = a + b;
			ALU_SUB: res = a - b;
			default: res = a - b;
		endcase
	end

	assign le = (a <= b);

endmodule

// ===== rtl/gtcl_rom.sv =====
// Per-year lunar calendar table with year length decode.
module gtcl_rom
	import gtcl_pkg::*;
(
	input logic [IDX_W-1:0] idx,
	output rom_info_t info
);

	localparam logic [WORD_W-1:0] MOON_ROM [TABLE_YEARS] = '{
		17'h04bd8,17'h04ae0,17'h0a570,17'h054d5,17'h0d260,17'h0d950,17'h16554,17'h056a0,
		17'h09ad0,17'h055d2,17'h04ae0,17'h0a5b6,17'h0a4d0,17'h0d250,17'h1d255,17'h0b540,
		17'h0d6a0,17'h0ada2,17'h095b0,17'h14977,17'h04970,17'h0a4b0,17'h0b4b5,17'h06a50,
		17'h06d40,17'h1ab54,17'h02b60,17'h09570,17'h052f2,17'h04970,17'h06566,17'h0d4a0,
		17'h0ea50,17'h06e95,17'h05ad0,17'h02b60,17'h186e3,17'h092e0,17'h1c8d7,17'h0c950,
		17'h0d4a0,17'h1d8a6,17'h0b550,17'h056a0,17'h1a5b4,17'h025d0,17'h092d0,17'h0d2b2,
		17'h0a950,17'h0b557,17'h06ca0,17'h0b550,17'h15355,17'h04da0,17'h0a5b0,17'h14573,
		17'h052b0,17'h0a9a8,17'h0e950,17'h06aa0,17'h0aea6,17'h0ab50,17'h04b60,17'h0aae4,
		17'h0a570,17'h05260,17'h0f263,17'h0d950,17'h05b57,17'h056a0,17'h096d0,17'h04dd5,
		17'h04ad0,17'h0a4d0,17'h0d4d4,17'h0d250,17'h0d558,17'h0b540,17'h0b6a0,17'h195a6,
		17'h095b0,17'h049b0,17'h0a974,17'h0a4b0,17'h0b27a,17'h06a50,17'h06d40,17'h0af46,
		17'h0ab60,17'h09570,17'h04af5,17'h04970,17'h064b0,17'h074a3,17'h0ea50,17'h06b58,
		17'h055c0,17'h0ab60,17'h096d5,17'h092e0,17'h0c960,17'h0d954,17'h0d4a0,17'h0da50,
		17'h07552,17'h056a0,17'h0abb7,17'h025d0,17'h092d0,17'h0cab5,17'h0a950,17'h0b4a0,
		17'h0baa4,17'h0ad50,17'h055d9,17'h04ba0,17'h0a5b0,17'h15176,17'h052b0,17'h0a930,
		17'h07954,17'h06aa0,17'h0ad50,17'h05b52,17'h04b60,17'h0a6e6,17'h0a4e0,17'h0d260,
		17'h0ea65,17'h0d530,17'h05aa0,17'h076a3,17'h096d0,17'h04bd7,17'h04ad0,17'h0a4d0,
		17'h1d0b6,17'h0d250,17'h0d520,17'h0dd45,17'h0b5a0,17'h056d0,17'h055b2,17'h049b0,
		17'h0a577,17'h0a4b0,17'h0aa50,17'h1b255,17'h06d20,17'h0ada0,17'h14b63,17'h09370
	};

	logic [WORD_W-1:0] w;
	logic [8:0] leap_days;

	assign w = MOON_ROM[idx];
	assign leap_days = (w[3:0] == 4'd0) ? 9'd0 : (w[16] ? 9'd30 : 9'd29);

	assign info.word = w;
	assign info.leap_mon = w[3:0];
	assign info.year_len = 9'd348 + 9'($countones(w[15:4])) + leap_days;

endmodule

// ===== rtl/gregorian_to_chinese_lunar_unit.sv =====
// Top level: sequencer converting a Gregorian date to a Chinese lunar date.
//
// One request is taken at a time; s_tready is high only while the sequencer is idle. A rejected
// date goes from the check state straight to the output state. An accepted date passes the setup
// states, then steps through lunar years from 1900 (up to 151) and then lunar months (up to 13).
// The stepping runs on the single shared add/subtract unit, which walks the year table one entry
// per cycle and then the months of the found year. The result waits in an output register, so the
// next request is taken while an earlier result is still pending.
module gregorian_to_chinese_lunar_unit
	import gtcl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [23:0] s_tdata, // greg_year[11:0], greg_month[15:12], greg_day[20:16]
	output logic m_tvalid,
	input logic m_tready,
	output logic [47:0] m_tdata // date_ok, moon_year, moon_month, moon_day, is_leap_month,
	                            // packed_date
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_MADD = 3'd2;
	localparam logic [2:0] ST_SUB30 = 3'd3;
	localparam logic [2:0] ST_YEAR = 3'd4;
	localparam logic [2:0] ST_MONTH = 3'd5;
	localparam logic [2:0] ST_FIN = 3'd6;

	logic [2:0] state_q;
	logic [11:0] y_q;
	logic [3:0] mo_q;
	logic [4:0] dy_q;
	logic ok_q;
	logic [D_W-1:0] d_q;
	logic [IDX_W-1:0] idx_q;
	logic [3:0] m_q;
	logic lph_q;
	logic [3:0] rm_q;
	logic [4:0] rd_q;
	logic rl_q;

	logic out_valid_q;
	logic out_ok_q;
	logic [11:0] out_year_q;
	logic [3:0] out_month_q;
	logic [4:0] out_day_q;
	logic out_leap_q;
	logic [24:0] out_packed_q;

	alu_op_t alu_op;
	logic [D_W-1:0] alu_b;
	logic [D_W-1:0] alu_res;
	logic alu_le;
	rom_info_t info;

	logic leap_yr;
	logic [4:0] sun_len;
	logic date_ok;
	logic [7:0] yo;
	logic [7:0] leap_cnt;
	logic [D_W-1:0] yrs_days;
	logic [8:0] cum_days;
	logic [8:0] month_off;
	logic [4:0] cur_len;
	logic [4:0] m12_len;
	logic [11:0] moon_yr;
	logic [24:0] packed_val;
	logic out_free;

	function automatic logic [4:0] sun_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] cum_before(input logic [3:0] m);
		logic [8:0] c;
		unique case (m)
			4'd1: c = 9'd0;
			4'd2: c = 9'd31;
			4'd3: c = 9'd59;
			4'd4: c = 9'd90;
			4'd5: c = 9'd120;
			4'd6: c = 9'd151;
			4'd7: c = 9'd181;
			4'd8: c = 9'd212;
			4'd9: c = 9'd243;
			4'd10: c = 9'd273;
			4'd11: c = 9'd304;
			4'd12: c = 9'd334;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

	gtcl_alu u_alu (
		.op(alu_op),
		.a(d_q),
		.b(alu_b),
		.res(alu_res),
		.le(alu_le)
	);

	gtcl_rom u_rom (
		.idx(idx_q),
		.info(info)
	);

	// within the table range only 1900 is a century year that is not leap
	assign leap_yr = (y_q[1:0] == 2'd0) && (y_q != BASE_YEAR);
	assign sun_len = sun_days(mo_q, leap_yr);
	assign date_ok = (y_q >= BASE_YEAR) && (y_q <= TOP_YEAR) && (mo_q >= 4'd1) &&
		(mo_q <= 4'd12) && !((y_q == BASE_YEAR) && (mo_q == 4'd1)) &&
		(dy_q != 5'd0) && (dy_q <= sun_len);

	assign yo = 8'(y_q - BASE_YEAR);
	assign leap_cnt = (yo == 8'd0) ? 8'd0 : ((yo - 8'd1) >> 2);
	assign yrs_days = D_W'(yo) * D_W'(365) + D_W'(leap_cnt);
	assign cum_days = cum_before(mo_q);
	assign month_off = cum_days + 9'(leap_yr && (mo_q > 4'd2)) + 9'(dy_q);

	assign cur_len = lph_q ? (info.word[16] ? 5'd30 : 5'd29) :
		(info.word[5'd16 - {1'b0, m_q}] ? 5'd30 : 5'd29);
	assign m12_len = info.word[4] ? 5'd30 : 5'd29;

	always_comb begin
		alu_op = ALU_SUB;
		alu_b = '0;
		unique case (state_q)
			ST_MADD: begin
				alu_op = ALU_ADD;
				alu_b = D_W'(month_off);
			end
			ST_SUB30: alu_b = D_W'(30);
			ST_YEAR: alu_b = D_W'(info.year_len);
			ST_MONTH: alu_b = D_W'(cur_len);
			default: alu_b = '0;
		endcase
	end

	assign moon_yr = BASE_YEAR + 12'(idx_q);
	assign packed_val = 25'(moon_yr) * 25'(10000) + 25'(rm_q) * 25'(100) + 25'(rd_q);
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: state_q <= date_ok ? ST_MADD : ST_FIN;
				ST_MADD: state_q <= ST_SUB30;
				ST_SUB30: state_q <= ST_YEAR;
				ST_YEAR: begin
					if (alu_le || (idx_q == LAST_IDX)) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (alu_le || ((lph_q || (info.leap_mon != m_q)) && (m_q == 4'd12))) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				y_q <= s_tdata[11:0];
				mo_q <= s_tdata[15:12];
				dy_q <= s_tdata[20:16];
			end
			ST_CHECK: begin
				ok_q <= date_ok;
				d_q <= yrs_days;
				idx_q <= '0;
			end
			ST_MADD, ST_SUB30: d_q <= alu_res;
			ST_YEAR: begin
				if (!alu_le && (idx_q != LAST_IDX)) begin
					d_q <= alu_res;
					idx_q <= idx_q + IDX_W'(1);
				end else begin
					m_q <= 4'd1;
					lph_q <= 1'b0;
				end
			end
			ST_MONTH: begin
				if (alu_le) begin
					rm_q <= m_q;
					rd_q <= d_q[4:0];
					rl_q <= lph_q;
				end else begin
					d_q <= alu_res;
					if (!lph_q && (info.leap_mon == m_q)) begin
						lph_q <= 1'b1;
					end else if (m_q == 4'd12) begin
						// ran past the year: last day of month twelve
						rm_q <= 4'd12;
						rd_q <= m12_len;
						rl_q <= 1'b0;
					end else begin
						lph_q <= 1'b0;
						m_q <= m_q + 4'd1;
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_ok_q <= ok_q;
					out_year_q <= ok_q ? moon_yr : 12'd0;
					out_month_q <= ok_q ? rm_q : 4'd0;
					out_day_q <= ok_q ? rd_q : 5'd0;
					out_leap_q <= ok_q ? rl_q : 1'b0;
					out_packed_q <= ok_q ? packed_val : 25'd0;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_packed_q, out_leap_q, out_day_q, out_month_q, out_year_q, out_ok_q};

`ifndef SYNTHESIS
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_CHECK))
		else $error("request accepted but check not started");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH) |-> ((m_q >= 4'd1) && (m_q <= 4'd12)))
		else $error("month step out of range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_YEAR) || (state_q == ST_MONTH)) |-> (idx_q <= LAST_IDX))
		else $error("year index past table");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !out_ok_q) |-> (m_tdata[47:1] == 47'd0))
		else $error("rejected date with non-zero fields");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_ok_q) |-> ((out_day_q != 5'd0) && (out_day_q <= 5'd30) &&
		(out_month_q >= 4'd1) && (out_month_q <= 4'd12)))
		else $error("converted date fields out of range");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !m_tready) |=> (state_q == ST_FIN))
		else $error("result overwritten before taken");
`endif

endmodule
